>>> hdl/two_way_set_assoc_cache_fifo_top_defines.svh
// assertion macros for the two-way set associative cache
// used by two_way_set_assoc_cache_fifo_top, expects clk and rst in scope
`ifndef TWO_WAY_SET_ASSOC_CACHE_FIFO_TOP_DEFINES_SVH
`define TWO_WAY_SET_ASSOC_CACHE_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// general property check, disabled during reset
`define TSAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication check, disabled during reset
`define TSAC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define TSAC_ASSERT(lbl, prop, msg)
`define TSAC_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/tsac_pkg.sv
// shared types and constants for the two-way set associative cache
// no dependencies
`timescale 1ns / 1ps

package tsac_pkg;

  localparam int unsigned SETS_DEF      = 4;
  localparam int unsigned MEM_WORDS_DEF = 64;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT   = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_RESOLVE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the request
    logic resolve;  // compare, fill and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free; // result register can take a new item this cycle
  } sts_t;

endpackage

>>> hdl/tsac_req_if.sv
// request channel: address and backing byte
// depends on tsac_pkg
`timescale 1ns / 1ps

interface tsac_req_if;
  logic                        valid;
  logic                        ready;
  logic [tsac_pkg::ADDR_W-1:0] address;
  logic [tsac_pkg::DATA_W-1:0] fill_data;

  modport source (output valid, output address, output fill_data, input ready);
  modport sink   (input valid, input address, input fill_data, output ready);
endinterface

>>> hdl/tsac_rsp_if.sv
// response channel: status, byte and way
// depends on tsac_pkg
`timescale 1ns / 1ps

interface tsac_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [tsac_pkg::STATUS_W-1:0] status;
  logic [tsac_pkg::DATA_W-1:0]   read_data;
  logic                          hit_way;

  modport source (output valid, output status, output read_data, output hit_way,
                  input ready);
  modport sink   (input valid, input status, input read_data, input hit_way,
                  output ready);
endinterface

>>> hdl/two_way_set_assoc_cache_fifo_top.sv
// top level of the two-way set associative byte cache, round-robin fill
// depends on tsac_pkg, tsac_req_if, tsac_rsp_if, tsac_ctrl, tsac_dpath
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  address[7:0], fill_data[7:0]
//  rsp      out  valid/ready  status[1:0], read_data[7:0], hit_way
//
// a request passes capture, tag/data memory read and resolve in turn;
// the registered read of the tag and data memories adds the middle step
// a result waits in its own register; the next request is taken while it waits
// a stalled response holds the resolve step until the result register frees up
// synchronous reset clears valid and victim bits and the handshake state;
// no clearing pass, the valid bits stand in for the zeroed stores
`timescale 1ns / 1ps
`include "two_way_set_assoc_cache_fifo_top_defines.svh"

module two_way_set_assoc_cache_fifo_top #(
  parameter int unsigned SETS      = tsac_pkg::SETS_DEF,
  parameter int unsigned MEM_WORDS = tsac_pkg::MEM_WORDS_DEF
) (
  input logic      clk,
  input logic      rst,
  tsac_req_if.sink   req,
  tsac_rsp_if.source rsp
);

  // command and status between sequencer and datapath
  tsac_pkg::cmd_t cmd;
  tsac_pkg::sts_t sts;

  tsac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsac_dpath #(
    .SETS      (SETS),
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_address    (req.address),
    .in_fill_data  (req.fill_data),
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .out_status    (rsp.status),
    .out_read_data (rsp.read_data),
    .out_hit_way   (rsp.hit_way)
  );

  // resolve only when the result register can take the item
  `TSAC_ASSERT_IMP(a_resolve_free, cmd.resolve, sts.out_free, "resolve while result register busy")

  // a resolved item shows up on the response channel next cycle
  `TSAC_ASSERT(a_resolve_shows, cmd.resolve |=> rsp.valid, "resolved item not presented")

  // no second request taken while one is in flight
  `TSAC_ASSERT(a_one_in_flight, (req.valid && req.ready) |=> !req.ready, "request taken while busy")

  // out of range results carry zero byte and way
  `TSAC_ASSERT_IMP(a_range_zero, rsp.valid && (rsp.status == tsac_pkg::ST_RANGE),
                   (rsp.read_data == '0) && !rsp.hit_way, "range error with nonzero payload")

endmodule

>>> hdl/tsac_ctrl.sv
// sequencing state machine for the cache: accept, lookup, resolve
// depends on tsac_pkg
`timescale 1ns / 1ps

module tsac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tsac_pkg::sts_t  sts,
  output tsac_pkg::cmd_t  cmd
);

  tsac_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsac_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.resolve = 1'b0;
    unique case (state)
      tsac_pkg::S_IDLE: begin
        // nothing is taken while reset is held
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = tsac_pkg::S_LOOKUP;
        end
      end
      tsac_pkg::S_LOOKUP: begin
        // tag and data read is in flight
        state_next = tsac_pkg::S_RESOLVE;
      end
      tsac_pkg::S_RESOLVE: begin
        if (sts.out_free) begin
          cmd.resolve = 1'b1;
          state_next  = tsac_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsac_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/tsac_dpath.sv
// cache datapath: request registers, tag and data memories, valid and
// victim bits, hit compare, fill and result register; depends on tsac_pkg
`timescale 1ns / 1ps

module tsac_dpath #(
  parameter int unsigned SETS      = tsac_pkg::SETS_DEF,
  parameter int unsigned MEM_WORDS = tsac_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tsac_pkg::cmd_t                cmd,
  output tsac_pkg::sts_t                sts,
  input  logic [tsac_pkg::ADDR_W-1:0]   in_address,
  input  logic [tsac_pkg::DATA_W-1:0]   in_fill_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tsac_pkg::STATUS_W-1:0] out_status,
  output logic [tsac_pkg::DATA_W-1:0]   out_read_data,
  output logic                          out_hit_way
);

  localparam int unsigned ADDR_N    = 1 << tsac_pkg::ADDR_W;
  localparam int unsigned ADDR_SPAN = (MEM_WORDS < ADDR_N) ? MEM_WORDS : ADDR_N;
  localparam int unsigned SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned TAG_N     = (ADDR_SPAN + SETS - 1) / SETS;
  localparam int unsigned TAG_W     = (TAG_N > 1) ? $clog2(TAG_N) : 1;
  localparam logic [tsac_pkg::ADDR_W:0] LIMIT = (tsac_pkg::ADDR_W + 1)'(ADDR_SPAN);

  // address split, worked out per address at elaboration
  logic [SET_W-1:0] set_lut [ADDR_N];
  logic [TAG_W-1:0] tag_lut [ADDR_N];

  for (genvar g = 0; g < ADDR_N; g++) begin : g_split
    assign set_lut[g] = SET_W'(g % SETS);
    assign tag_lut[g] = TAG_W'(g / SETS);
  end

  logic [tsac_pkg::ADDR_W-1:0] addr_q;
  logic [tsac_pkg::DATA_W-1:0] fill_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_q <= in_address;
      fill_q <= in_fill_data;
    end
  end

  logic [SET_W-1:0] set_idx;
  logic [TAG_W-1:0] tag;
  logic             in_range;

  assign set_idx  = set_lut[addr_q];
  assign tag      = tag_lut[addr_q];
  assign in_range = {1'b0, addr_q} < LIMIT;

  // tag and data stores, registered read
  logic [TAG_W-1:0]            tag0_mem  [SETS];
  logic [TAG_W-1:0]            tag1_mem  [SETS];
  logic [tsac_pkg::DATA_W-1:0] data0_mem [SETS];
  logic [tsac_pkg::DATA_W-1:0] data1_mem [SETS];

  logic [TAG_W-1:0]            rd_tag0, rd_tag1;
  logic [tsac_pkg::DATA_W-1:0] rd_data0, rd_data1;

  logic [SETS-1:0] valid0, valid1, victim;
  logic            hit0, hit1, fill_en, fill_way;

  assign hit0     = valid0[set_idx] && (rd_tag0 == tag);
  assign hit1     = valid1[set_idx] && (rd_tag1 == tag);
  assign fill_way = victim[set_idx];
  assign fill_en  = cmd.resolve && in_range && !hit0 && !hit1;

  always_ff @(posedge clk) begin
    rd_tag0  <= tag0_mem[set_idx];
    rd_tag1  <= tag1_mem[set_idx];
    rd_data0 <= data0_mem[set_idx];
    rd_data1 <= data1_mem[set_idx];
    if (fill_en && !fill_way) begin
      tag0_mem[set_idx]  <= tag;
      data0_mem[set_idx] <= fill_q;
    end
    if (fill_en && fill_way) begin
      tag1_mem[set_idx]  <= tag;
      data1_mem[set_idx] <= fill_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid0 <= '0;
      valid1 <= '0;
      victim <= '0;
    end else if (fill_en) begin
      if (fill_way) begin
        valid1[set_idx] <= 1'b1;
      end else begin
        valid0[set_idx] <= 1'b1;
      end
      victim[set_idx] <= !fill_way;
    end
  end

  // result register
  tsac_pkg::status_t           status_q;
  logic [tsac_pkg::DATA_W-1:0] data_q;
  logic                        way_q;

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      if (!in_range) begin
        status_q <= tsac_pkg::ST_RANGE;
        data_q   <= '0;
        way_q    <= 1'b0;
      end else if (hit0) begin
        status_q <= tsac_pkg::ST_HIT;
        data_q   <= rd_data0;
        way_q    <= 1'b0;
      end else if (hit1) begin
        status_q <= tsac_pkg::ST_HIT;
        data_q   <= rd_data1;
        way_q    <= 1'b1;
      end else begin
        status_q <= tsac_pkg::ST_MISS;
        data_q   <= fill_q;
        way_q    <= fill_way;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.resolve) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign out_status    = status_q;
  assign out_read_data = data_q;
  assign out_hit_way   = way_q;

endmodule
